// ===== hw/rtl/civ_pkg.sv =====
// package for the catalog image validator: word types, codes, header layout, crc step
`timescale 1ns / 1ps
package civ_pkg;

  // byte counter width
  localparam int LENGTH_W = 32;
  localparam logic [LENGTH_W-1:0] LEN_MAX = '1;

  // header layout
  localparam int HDR_BYTES = 28;
  localparam int HDR_IDX_W = 5;
  localparam logic [31:0] HDR_SIZE = 32'd32;
  localparam logic [15:0] FMT_VERSION = 16'd2;
  localparam int REC_SHIFT = 5;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
  localparam logic [31:0] MAGIC = 32'h3143_4245;
  // largest record count that still fits after a 32 byte record offset
  localparam logic [31:0] MAX_COUNT = (ALL_ONES - HDR_SIZE) / 32'd32;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_OLD   = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] record_count;
  } out_word_t;

  // one finished file handed from front to back
  typedef struct packed {
    logic        trunc;
    logic        sat;
    logic        magic_ok;
    logic [31:0] len;
    logic [15:0] version;
    logic [15:0] hsize;
    logic [31:0] count;
    logic [31:0] rec_at;
    logic [31:0] str_at;
    logic [31:0] str_size;
    logic [31:0] stored;
    logic [31:0] crc;
  } job_t;

  // check results registered in the back end
  typedef struct packed {
    logic        trunc;
    logic        sat;
    logic        all_ok;
    logic        older;
    logic [31:0] count;
  } chk_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/catalog_image_validator_unit.sv =====
// top level of the catalog image validator
`timescale 1ns / 1ps
// Takes one file byte per cycle through push/full while full is low, with last_byte
// marking the final byte, and gives one result word (status, record_count) per file
// through empty/pop. Files stream at one byte per clock while full is low; a file's job
// passes from the job queue through the registered check stage into the result queue,
// whose head shows on the result ports. A two-entry job queue and a two-entry result queue
// sit between the byte path and the output; full rises only when both are backed up by a
// stalled result side, and then holds every byte until the back end frees a job slot.
module catalog_image_validator_unit import civ_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_word_t  item,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  logic accept;
  logic job_push;
  job_t job_in;
  logic job_valid;
  logic job_pop;
  job_t job_out;

  assign accept = push & !full;

  // byte path
  civ_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job_in)
  );

  // job queue
  civ_job_fifo u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .wdata    (job_in),
    .full     (full),
    .rd_valid (job_valid),
    .pop      (job_pop),
    .rdata    (job_out)
  );

  // checks and results
  civ_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== hw/rtl/civ_front.sv =====
// front end: counts bytes, keeps the header, runs the crc, emits one job per file
`timescale 1ns / 1ps
module civ_front import civ_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_word_t item,
  output logic     job_push,
  output job_t     job
);

  logic [LENGTH_W-1:0] byte_total;
  logic                length_saturated;
  logic [31:0]         crc_running;
  logic [7:0]          hdr [HDR_BYTES];

  logic [LENGTH_W-1:0] total_next;
  logic                sat_next;
  logic [31:0]         crc_next;
  logic                at_max;

  // next counter and crc values for this byte
  always_comb begin
    at_max     = (byte_total == LEN_MAX);
    sat_next   = length_saturated | at_max;
    total_next = at_max ? byte_total : byte_total + 1'b1;
    crc_next   = (32'(byte_total) >= HDR_SIZE) ? crc_byte(crc_running, item.data_byte)
                                               : crc_running;
  end

  // running state, cleared after the last byte of a file
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total       <= '0;
      length_saturated <= 1'b0;
      crc_running      <= ALL_ONES;
    end else if (accept) begin
      if (item.last_byte) begin
        byte_total       <= '0;
        length_saturated <= 1'b0;
        crc_running      <= ALL_ONES;
      end else begin
        byte_total       <= total_next;
        length_saturated <= sat_next;
        crc_running      <= crc_next;
      end
    end
  end

  // header byte store
  always_ff @(posedge clk) begin
    if (accept && (32'(byte_total) < 32'(HDR_BYTES))) begin
      hdr[byte_total[HDR_IDX_W-1:0]] <= item.data_byte;
    end
  end

  // job word for the finished file
  always_comb begin
    job_push     = accept & item.last_byte;
    job.sat      = sat_next;
    job.trunc    = !sat_next && (32'(total_next) < HDR_SIZE);
    job.len      = 32'(total_next);
    job.magic_ok = ({hdr[3], hdr[2], hdr[1], hdr[0]} == MAGIC);
    job.version  = {hdr[5], hdr[4]};
    job.hsize    = {hdr[7], hdr[6]};
    job.count    = {hdr[11], hdr[10], hdr[9], hdr[8]};
    job.rec_at   = {hdr[15], hdr[14], hdr[13], hdr[12]};
    job.str_at   = {hdr[19], hdr[18], hdr[17], hdr[16]};
    job.str_size = {hdr[23], hdr[22], hdr[21], hdr[20]};
    job.stored   = {hdr[27], hdr[26], hdr[25], hdr[24]};
    job.crc      = crc_next;
  end

endmodule

// ===== hw/rtl/civ_job_fifo.sv =====
// two entry queue of finished-file jobs between front and back
`timescale 1ns / 1ps
module civ_job_fifo import civ_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  output logic rd_valid,
  input  logic pop,
  output job_t rdata
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt == 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rdata    = mem[rd_ptr];
  assign do_push  = push & !full;
  assign do_pop   = pop & rd_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

// ===== hw/rtl/civ_back.sv =====
// back end: header checks, status decision and result queue
`timescale 1ns / 1ps
module civ_back import civ_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  logic       s1_valid;
  chk_t       s1;
  chk_t       chk_next;
  out_word_t  res_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       res_full;
  logic       res_push;
  logic       res_pop;
  out_word_t  res_word;
  logic       s1_ready;

  assign res_full = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign res_push = s1_valid & !res_full;
  assign res_pop  = pop & !empty;
  assign s1_ready = !s1_valid | res_push;
  assign job_pop  = job_valid & s1_ready;
  assign result   = res_mem[rd_ptr];

  // field checks on the job word
  always_comb begin
    logic ok;
    ok = job.magic_ok &&
         (job.version == FMT_VERSION) &&
         (job.hsize == HDR_SIZE[15:0]) &&
         (job.rec_at == HDR_SIZE) &&
         (job.count <= MAX_COUNT) &&
         (job.str_at == HDR_SIZE + (job.count << REC_SHIFT)) &&
         (job.str_size <= job.len) &&
         (job.str_at <= job.len - job.str_size) &&
         (job.str_at + job.str_size == job.len) &&
         (job.stored == ~job.crc);
    chk_next.trunc  = job.trunc;
    chk_next.sat    = job.sat;
    chk_next.all_ok = ok;
    chk_next.older  = job.magic_ok && (job.version < FMT_VERSION);
    chk_next.count  = job.count;
  end

  // check stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) s1 <= chk_next;
  end

  // status decision
  always_comb begin
    res_word.record_count = '0;
    if (s1.trunc) begin
      res_word.status = ST_TRUNC;
    end else if (s1.sat) begin
      res_word.status = ST_BAD;
    end else if (s1.all_ok) begin
      res_word.status       = ST_OK;
      res_word.record_count = s1.count;
    end else if (s1.older) begin
      res_word.status = ST_OLD;
    end else begin
      res_word.status = ST_BAD;
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (res_push) wr_ptr <= !wr_ptr;
      if (res_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (res_push) res_mem[wr_ptr] <= res_word;
  end

endmodule

// ===== hw/rtl/civ_checker.sv =====
// port-level checks for the catalog image validator, bound to the top level
`timescale 1ns / 1ps
module civ_checker import civ_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input in_word_t  item,
  input logic      empty,
  input logic      pop,
  input out_word_t result
);

  // queues come out of reset empty and open
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result queue not empty or input full after reset");

  // only an ok result carries a record count
  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != ST_OK) |-> (result.record_count == 32'd0))
    else $error("nonzero record count on a failing result");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // no result can appear without a prior accepted byte when nothing was waiting
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (empty && $past(empty) && $past(empty, 2) && $past(empty, 3) &&
     !$past(push && !full) && !$past(push && !full, 2) && !$past(push && !full, 3) &&
     !$past(rst) && !$past(rst, 2) && !$past(rst, 3) && !$past(full))
    |=> empty)
    else $error("result appeared without input");

endmodule

bind catalog_image_validator_unit civ_checker u_civ_checker (.*);

// ===== dv/catalog_image_validator_unit_tb.sv =====
// testbench for the catalog image validator: file stimulus, predictor and result checks
`timescale 1ns / 1ps
module catalog_image_validator_unit_tb;
  import civ_pkg::*;

  // ways a well-formed file gets broken
  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_OLD,
    FLAW_NEWER,
    FLAW_HSIZE,
    FLAW_RECAT,
    FLAW_COUNT,
    FLAW_STRAT,
    FLAW_STRSIZE,
    FLAW_CRC,
    FLAW_BODY,
    FLAW_CUT,
    FLAW_EXTRA,
    FLAW_OVERFLOW,
    FLAW_WRAP
  } flaw_e;

  // predicts the verdict for each file and checks the words that come out
  class catalog_checker;
    logic [LENGTH_W-1:0] byte_total;
    bit                  len_sat;
    logic [31:0]         crc_reg;
    logic [7:0]          hdr_bytes [HDR_BYTES];
    out_word_t           verdict_q [$];
    int                  errors;
    int                  status_tally [4];
    int                  files_seen;

    function new();
      errors = 0;
      files_seen = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      start_file();
    endfunction

    function void start_file();
      byte_total = '0;
      len_sat = 1'b0;
      crc_reg = ALL_ONES;
    endfunction

    // reflected crc-32, bit serial, lsb of the byte first
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ b[i];
        r = r >> 1;
        if (fb) r = r ^ CRC_POLY;
      end
      return r;
    endfunction

    function logic [15:0] hdr16(int at);
      return {hdr_bytes[at+1], hdr_bytes[at]};
    endfunction

    function logic [31:0] hdr32(int at);
      return {hdr_bytes[at+3], hdr_bytes[at+2], hdr_bytes[at+1], hdr_bytes[at]};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // one accepted input word; the final byte of a file yields a verdict
    task take_byte(in_word_t w);
      out_word_t   v;
      logic [31:0] len, count, rec_at, str_at, str_size, stored, lim, rec_end, sum, room;
      logic [15:0] version, hsize;
      bit          magic_good, bad;
      if (byte_total < HDR_BYTES) hdr_bytes[byte_total[HDR_IDX_W-1:0]] = w.data_byte;
      if (byte_total >= HDR_SIZE) crc_reg = crc_step(crc_reg, w.data_byte);
      if (byte_total == LEN_MAX) len_sat = 1'b1;
      else byte_total = byte_total + 1'b1;
      if (!w.last_byte) return;

      v.record_count = '0;
      if (!len_sat && byte_total < HDR_SIZE) begin
        v.status = ST_TRUNC;
      end else if (len_sat) begin
        v.status = ST_BAD;
      end else begin
        len = 32'(byte_total);
        version = hdr16(4);
        hsize = hdr16(6);
        count = hdr32(8);
        rec_at = hdr32(12);
        str_at = hdr32(16);
        str_size = hdr32(20);
        stored = hdr32(24);
        magic_good = (hdr32(0) == MAGIC);
        lim = (ALL_ONES - rec_at) / 32'd32;
        rec_end = rec_at + (count << REC_SHIFT);
        sum = str_at + str_size;
        room = len - str_size;
        bad = !magic_good || version != FMT_VERSION || {16'd0, hsize} != HDR_SIZE ||
              rec_at != HDR_SIZE || count > lim || str_at != rec_end ||
              str_size > len || str_at > room || sum != len || stored != ~crc_reg;
        if (!bad) begin
          v.status = ST_OK;
          v.record_count = count;
        end else if (magic_good && version < FMT_VERSION) begin
          v.status = ST_OLD;
        end else begin
          v.status = ST_BAD;
        end
      end
      verdict_q.push_back(v);
      status_tally[v.status]++;
      files_seen++;
      start_file();
    endtask

    task check_verdict(out_word_t got);
      out_word_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected word status %0d count %0d",
                         got.status, got.record_count));
        return;
      end
      want = verdict_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.record_count !== want.record_count)
        report($sformatf("record_count got %0d want %0d",
                         got.record_count, want.record_count));
    endtask
  endclass

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_word_t  item;
  logic      empty;
  logic      pop;
  out_word_t result;

  catalog_checker sb;
  logic [7:0]     file_q [$];
  int             bytes_sent;
  int             files_sent;
  bit             calm_send;
  bit             calm_recv;

  catalog_image_validator_unit uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function void put16(int at, logic [15:0] v);
    file_q[at] = v[7:0];
    file_q[at+1] = v[15:8];
  endfunction

  function void put32(int at, logic [31:0] v);
    for (int i = 0; i < 4; i++) file_q[at+i] = v[8*i +: 8];
  endfunction

  // flip one bit somewhere in a byte range
  function void flip_bit(int lo, int nbytes);
    int k;
    k = lo + $urandom_range(0, nbytes - 1);
    file_q[k] = file_q[k] ^ (8'd1 << $urandom_range(0, 7));
  endfunction

  // checksum over everything past the header, stored at offset 24
  function void seal_crc();
    logic [31:0] c;
    c = ALL_ONES;
    for (int i = 32; i < file_q.size(); i++) c = catalog_checker::crc_step(c, file_q[i]);
    put32(24, ~c);
  endfunction

  // well-formed file with random records and string table
  function void build_file(int n_rec, int str_len);
    int total;
    total = 32 + 32 * n_rec + str_len;
    file_q.delete();
    for (int i = 0; i < total; i++) file_q.push_back(8'($urandom));
    put32(0, MAGIC);
    put16(4, FMT_VERSION);
    put16(6, HDR_SIZE[15:0]);
    put32(8, n_rec);
    put32(12, HDR_SIZE);
    put32(16, 32 + 32 * n_rec);
    put32(20, str_len);
    seal_crc();
  endfunction

  function void apply_flaw(flaw_e f);
    case (f)
      FLAW_MAGIC:    flip_bit(0, 4);
      FLAW_OLD:      put16(4, 16'($urandom_range(0, 1)));
      FLAW_NEWER:    put16(4, 16'($urandom_range(3, 65535)));
      FLAW_HSIZE:    flip_bit(6, 2);
      FLAW_RECAT:    flip_bit(12, 4);
      FLAW_COUNT:    flip_bit(8, 4);
      FLAW_STRAT:    flip_bit(16, 4);
      FLAW_STRSIZE:  flip_bit(20, 4);
      FLAW_CRC:      flip_bit(24, 4);
      FLAW_BODY: begin
        if (file_q.size() > 32) flip_bit(32, file_q.size() - 32);
        else flip_bit(24, 4);
      end
      FLAW_CUT: begin
        repeat ($urandom_range(1, 3)) void'(file_q.pop_back());
      end
      FLAW_EXTRA: begin
        repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom));
      end
      FLAW_OVERFLOW: begin
        // one past the largest count, table offset wraps to zero and all else holds; or any larger count
        if ($urandom_range(0, 1) == 0) begin
          put32(8, MAX_COUNT + 1);
          put32(16, 32'd0);
          put32(20, file_q.size());
        end else begin
          put32(8, $urandom_range(MAX_COUNT + 1, ALL_ONES));
        end
      end
      FLAW_WRAP: begin
        // largest legal count; table size past the length, offset + size wraps
        put32(8, MAX_COUNT);
        put32(16, 32'hffff_ffe0);
        put32(20, file_q.size() + 32);
      end
      default: ;
    endcase
  endfunction

  // offer one byte, hold it until taken
  task send_byte(logic [7:0] b, logic last);
    int gap;
    gap = calm_send ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (full);
    sb.take_byte(item);
    bytes_sent++;
  endtask

  task send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  task run_case(int n_rec, int str_len, flaw_e fa, flaw_e fb);
    build_file(n_rec, str_len);
    apply_flaw(fa);
    apply_flaw(fb);
    send_file();
  endtask

  // unstructured file; fill below zero means random bytes
  task run_noise(int len, int fill, bit with_magic);
    file_q.delete();
    for (int i = 0; i < len; i++) file_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    if (with_magic && len >= 6) begin
      put32(0, MAGIC);
      put16(4, 16'($urandom_range(0, 3)));
    end
    send_file();
  endtask

  // result side: random pop stalls with calm stretches
  initial begin
    int stall;
    stall = 0;
    calm_recv = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_verdict(result);
      if ($urandom_range(0, 299) == 0) calm_recv = !calm_recv;
      if (rst) begin
        pop <= 1'b0;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = calm_recv ? 0 : pick_gap();
      end
    end
  end

  // main sequence
  initial begin
    int r, n_rec, wait_left;
    flaw_e fa, fb;
    sb = new();
    bytes_sent = 0;
    files_sent = 0;
    calm_send = 1'b0;
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed files: short and header-sized noise, minimal and fuller valid ones, each flaw
    run_noise(1, -1, 1'b0);
    run_noise(31, 8'hff, 1'b0);
    run_noise(32, 8'h00, 1'b0);
    run_case(0, 0, FLAW_NONE, FLAW_NONE);
    run_case(1, 5, FLAW_NONE, FLAW_NONE);
    run_case(2, 0, FLAW_NONE, FLAW_NONE);
    run_case(0, 3, FLAW_MAGIC, FLAW_NONE);
    run_case(1, 0, FLAW_OLD, FLAW_NONE);
    run_case(0, 2, FLAW_OLD, FLAW_CRC);
    run_case(0, 0, FLAW_NEWER, FLAW_NONE);
    run_case(0, 1, FLAW_HSIZE, FLAW_NONE);
    run_case(1, 0, FLAW_RECAT, FLAW_NONE);
    run_case(1, 4, FLAW_COUNT, FLAW_NONE);
    run_case(0, 4, FLAW_STRAT, FLAW_NONE);
    run_case(1, 2, FLAW_STRSIZE, FLAW_NONE);
    run_case(0, 0, FLAW_CRC, FLAW_NONE);
    run_case(1, 1, FLAW_BODY, FLAW_NONE);
    run_case(0, 0, FLAW_CUT, FLAW_NONE);
    run_case(0, 6, FLAW_EXTRA, FLAW_NONE);
    run_case(0, 8, FLAW_OVERFLOW, FLAW_NONE);
    run_case(0, 3, FLAW_WRAP, FLAW_NONE);

    // random files: well formed, flawed or noise
    while (bytes_sent < 1150) begin
      calm_send = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      n_rec = (r < 4) ? 0 : (r < 8) ? 1 : 2;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        run_case(n_rec, $urandom_range(0, 16), FLAW_NONE, FLAW_NONE);
      end else if (r < 75) begin
        fa = flaw_e'($urandom_range(FLAW_MAGIC, FLAW_WRAP));
        fb = ($urandom_range(0, 3) == 0) ? flaw_e'($urandom_range(FLAW_MAGIC, FLAW_WRAP))
                                         : FLAW_NONE;
        run_case(n_rec, $urandom_range(0, 16), fa, fb);
      end else if (r < 87) begin
        run_noise($urandom_range(1, 31), -1, 1'b0);
      end else begin
        run_noise($urandom_range(32, 80), -1, 1'($urandom_range(0, 1)));
      end
    end
    push <= 1'b0;

    // drain
    wait_left = 5000;
    while (sb.verdict_q.size() != 0 && wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    if (sb.verdict_q.size() != 0)
      sb.report($sformatf("%0d expected words never arrived", sb.verdict_q.size()));
    repeat (20) @(posedge clk);

    $display("ran %0d files in %0d bytes: %0d ok, %0d short, %0d older, %0d invalid",
             files_sent, bytes_sent, sb.status_tally[ST_OK], sb.status_tally[ST_TRUNC],
             sb.status_tally[ST_OLD], sb.status_tally[ST_BAD]);
    $display("%0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== catalog_image_validator_unit.f =====
hw/rtl/civ_pkg.sv
hw/rtl/civ_front.sv
hw/rtl/civ_job_fifo.sv
hw/rtl/civ_back.sv
hw/rtl/catalog_image_validator_unit.sv
hw/rtl/civ_checker.sv
dv/catalog_image_validator_unit_tb.sv
